@@ rtl/pfs_pkg.sv @@
// shared types and constants for the playback flow sequencer
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 64;
  localparam int ERR_W     = 32;
  localparam int LEVEL_W   = 16;
  localparam int ACT_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] UNDERFLOW_RESET = 16'd8;
  localparam logic [LEVEL_W-1:0] OVERFLOW_RESET  = 16'd56;

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_LEVEL    = 2'd2,
    CMD_CANCEL   = 2'd3
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEEK     = 3'd0,
    ACT_PLAY     = 3'd1,
    ACT_PAUSE    = 3'd2,
    ACT_TEARDOWN = 3'd3,
    ACT_REPORT   = 3'd4,
    ACT_RELEASE  = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNDERFLOW = 1'b0,
    REG_OVERFLOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_SEEK_SENT  = 6'b000010,
    PH_PLAY_SENT  = 6'b000100,
    PH_PLAYING    = 6'b001000,
    PH_PAUSE_SENT = 6'b010000,
    PH_PAUSED     = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    MD_NORMAL      = 4'b0001,
    MD_CANCELLED   = 4'b0010,
    MD_TERMINATING = 4'b0100,
    MD_TERMINATED  = 4'b1000
  } mode_t;

  // one queued job: a single action, or report followed by teardown
  typedef struct packed {
    action_t           act;
    logic              pair;
    logic [TIME_W-1:0] cmd_time;
    logic [ERR_W-1:0]  err;
  } job_t;

endpackage

@@ rtl/pfs_ifs.sv @@
// channel interfaces: input items, result items and register writes
`timescale 1ns / 1ps

interface pfs_item_if;
  import pfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [TIME_W-1:0]    seek_time;
  logic [ERR_W-1:0]     error_code;
  logic [LEVEL_W-1:0]   queue_count;
  modport source (output valid, cmd, seek_time, error_code, queue_count, input ready);
  modport sink   (input valid, cmd, seek_time, error_code, queue_count, output ready);
endinterface

interface pfs_result_if;
  import pfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [TIME_W-1:0]    command_time;
  logic [ERR_W-1:0]     reported_error;
  logic                 last;
  modport source (output valid, action, command_time, reported_error, last, input ready);
  modport sink   (input valid, action, command_time, reported_error, last, output ready);
endinterface

interface pfs_cfg_if;
  import pfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEVEL_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/playback_flow_sequencer.sv @@
// an item's job is written to the queue when the item is taken; its first result then moves to the output register
// throughput: one item per cycle in while the queue is not full; the back end sends one
//   result per cycle while the sink is ready, and an error completion sends two (report then teardown)
// the job queue (QUEUE_DEPTH entries) lets the front keep taking items while results stall, until it is full
// reset: phase idle, mode normal, thresholds 8 and 56, queue and output register empty
`timescale 1ns / 1ps

module playback_flow_sequencer
  import pfs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  pfs_item_if.sink      item,
  pfs_cfg_if.sink       cfg,
  pfs_result_if.source  result
);

  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  pfs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cfg  (cfg),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  pfs_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  pfs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ rtl/pfs_front.sv @@
// front end: takes items, runs both state regions and queues the actions
`timescale 1ns / 1ps

module pfs_front
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pfs_item_if.sink    item,
  pfs_cfg_if.sink     cfg,
  input  logic        full,
  output logic        push,
  output job_t        job
);

  logic [LEVEL_W-1:0] underflow_threshold;
  logic [LEVEL_W-1:0] overflow_threshold;
  phase_t             main_phase, main_phase_next;
  mode_t              run_mode, run_mode_next;
  logic               take;
  logic               emit;
  cmd_t               cmd;

  assign item.ready = !full;
  assign cfg.ready  = 1'b1;
  assign take       = item.valid && item.ready;
  assign cmd        = cmd_t'(item.cmd);
  assign push       = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      underflow_threshold <= UNDERFLOW_RESET;
      overflow_threshold  <= OVERFLOW_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_UNDERFLOW: underflow_threshold <= cfg.data;
        REG_OVERFLOW:  overflow_threshold  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    main_phase_next = main_phase;
    run_mode_next   = run_mode;
    emit            = 1'b0;
    job.act         = ACT_TEARDOWN;
    job.pair        = 1'b0;
    job.cmd_time    = '0;
    job.err         = '0;
    if (run_mode != MD_TERMINATED) begin
      if (cmd == CMD_COMPLETE) begin
        if (run_mode == MD_CANCELLED) begin
          run_mode_next = MD_TERMINATING;
          emit          = 1'b1;
        end else if (run_mode == MD_TERMINATING) begin
          run_mode_next = MD_TERMINATED;
          emit          = 1'b1;
          job.act       = ACT_RELEASE;
        end else if (item.error_code != '0) begin
          // report then teardown, phase left where it was
          run_mode_next = MD_TERMINATING;
          emit          = 1'b1;
          job.act       = ACT_REPORT;
          job.pair      = 1'b1;
          job.err       = item.error_code;
        end else if (main_phase == PH_SEEK_SENT) begin
          main_phase_next = PH_PLAY_SENT;
          emit            = 1'b1;
          job.act         = ACT_PLAY;
        end else if (main_phase == PH_PLAY_SENT) begin
          main_phase_next = PH_PLAYING;
        end else if (main_phase == PH_PAUSE_SENT) begin
          main_phase_next = PH_PAUSED;
        end
      end else if (run_mode == MD_NORMAL) begin
        unique case (cmd)
          CMD_START: begin
            if (main_phase == PH_IDLE) begin
              main_phase_next = PH_SEEK_SENT;
              emit            = 1'b1;
              job.act         = ACT_SEEK;
              job.cmd_time    = item.seek_time;
            end
          end
          CMD_LEVEL: begin
            // overflow takes priority over underflow
            if (item.queue_count > overflow_threshold) begin
              if (main_phase == PH_PLAYING) begin
                main_phase_next = PH_PAUSE_SENT;
                emit            = 1'b1;
                job.act         = ACT_PAUSE;
              end
            end else if (item.queue_count < underflow_threshold) begin
              if (main_phase == PH_PAUSED) begin
                main_phase_next = PH_PLAY_SENT;
                emit            = 1'b1;
                job.act         = ACT_PLAY;
              end
            end
          end
          CMD_CANCEL: begin
            if (main_phase == PH_SEEK_SENT || main_phase == PH_PLAY_SENT ||
                main_phase == PH_PAUSE_SENT) begin
              run_mode_next = MD_CANCELLED;
            end else begin
              run_mode_next = MD_TERMINATING;
              emit          = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase <= PH_IDLE;
      run_mode   <= MD_NORMAL;
    end else if (take) begin
      main_phase <= main_phase_next;
      run_mode   <= run_mode_next;
    end
  end

endmodule

@@ rtl/pfs_queue.sv @@
// small job queue between front and back ends
`timescale 1ns / 1ps

module pfs_queue
  import pfs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(DEPTH));
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/pfs_back.sv @@
// back end: expands queued jobs into result transfers
`timescale 1ns / 1ps

module pfs_back
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  pfs_result_if.source result
);

  logic out_valid;
  logic second;
  logic load;

  assign load         = !out_valid || result.ready;
  assign pop          = load && !empty && (!head.pair || second);
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty && head.pair) begin
        second <= !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (head.pair && !second) begin
        result.action         <= ACT_REPORT;
        result.command_time   <= '0;
        result.reported_error <= head.err;
        result.last           <= 1'b0;
      end else if (head.pair) begin
        result.action         <= ACT_TEARDOWN;
        result.command_time   <= '0;
        result.reported_error <= '0;
        result.last           <= 1'b1;
      end else begin
        result.action         <= head.act;
        result.command_time   <= head.cmd_time;
        result.reported_error <= head.err;
        result.last           <= 1'b1;
      end
    end
  end

endmodule

@@ tb/playback_flow_sequencer_tb.sv @@
// self-checking testbench for the playback flow sequencer
`timescale 1ns / 1ps

module playback_flow_sequencer_tb;
  import pfs_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [TIME_W-1:0] seek;
    logic [ERR_W-1:0]  err;
    logic [LEVEL_W-1:0] level;
  } flow_item_t;

  typedef struct {
    action_t           act;
    logic [TIME_W-1:0] cmd_time;
    logic [ERR_W-1:0]  err;
    logic              last;
  } action_record_t;

  typedef enum int {
    END_CANCEL_BUSY,
    END_CANCEL_IDLE,
    END_ERROR
  } shutdown_path_t;

  logic clk;
  logic rst;

  pfs_item_if   item_ch ();
  pfs_cfg_if    cfg_ch ();
  pfs_result_if result_ch ();

  playback_flow_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  // predicted block state
  phase_t             stream_phase;
  mode_t              shutdown_mode;
  logic [LEVEL_W-1:0] underflow_thr;
  logic [LEVEL_W-1:0] overflow_thr;

  action_record_t expected_actions[$];
  int             fail_count;
  int             sent_items;
  int             sink_hold;
  bit             idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("playback_flow_sequencer verification failed");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    return LEVEL_W'($urandom());
  endfunction

  function automatic void push_action(action_t act, logic [TIME_W-1:0] t, logic [ERR_W-1:0] e);
    action_record_t rec;
    rec.act      = act;
    rec.cmd_time = t;
    rec.err      = e;
    rec.last     = 1'b0;
    expected_actions.push_back(rec);
  endfunction

  function automatic bit stream_busy();
    return stream_phase == PH_SEEK_SENT || stream_phase == PH_PLAY_SENT ||
           stream_phase == PH_PAUSE_SENT;
  endfunction

  // updates the predicted state and queues the results the item causes
  function automatic void predict_actions(flow_item_t it);
    int             base;
    action_record_t tail;
    base = expected_actions.size();
    if (shutdown_mode != MD_TERMINATED) begin
      if (it.cmd == CMD_COMPLETE) begin
        // the shutdown modes take the completion before any error or success
        if (shutdown_mode == MD_CANCELLED) begin
          shutdown_mode = MD_TERMINATING;
          push_action(ACT_TEARDOWN, '0, '0);
        end else if (shutdown_mode == MD_TERMINATING) begin
          shutdown_mode = MD_TERMINATED;
          push_action(ACT_RELEASE, '0, '0);
        end else if (it.err != '0) begin
          push_action(ACT_REPORT, '0, it.err);
          shutdown_mode = MD_TERMINATING;
          push_action(ACT_TEARDOWN, '0, '0);
        end else begin
          case (stream_phase)
            PH_SEEK_SENT: begin
              stream_phase = PH_PLAY_SENT;
              push_action(ACT_PLAY, '0, '0);
            end
            PH_PLAY_SENT:  stream_phase = PH_PLAYING;
            PH_PAUSE_SENT: stream_phase = PH_PAUSED;
            default: ;
          endcase
        end
      end else if (shutdown_mode == MD_NORMAL) begin
        case (it.cmd)
          CMD_START: begin
            if (stream_phase == PH_IDLE) begin
              stream_phase = PH_SEEK_SENT;
              push_action(ACT_SEEK, it.seek, '0);
            end
          end
          CMD_LEVEL: begin
            if (it.level > overflow_thr) begin
              if (stream_phase == PH_PLAYING) begin
                stream_phase = PH_PAUSE_SENT;
                push_action(ACT_PAUSE, '0, '0);
              end
            end else if (it.level < underflow_thr) begin
              if (stream_phase == PH_PAUSED) begin
                stream_phase = PH_PLAY_SENT;
                push_action(ACT_PLAY, '0, '0);
              end
            end
          end
          default: begin
            if (stream_busy()) begin
              shutdown_mode = MD_CANCELLED;
            end else begin
              shutdown_mode = MD_TERMINATING;
              push_action(ACT_TEARDOWN, '0, '0);
            end
          end
        endcase
      end
    end
    if (expected_actions.size() > base) begin
      tail = expected_actions.pop_back();
      tail.last = 1'b1;
      expected_actions.push_back(tail);
    end
  endfunction

  // valid stays high after the transfer so a back-to-back item follows without valid dropping in between
  task automatic send_item(cmd_t c, logic [TIME_W-1:0] s, logic [ERR_W-1:0] e,
                           logic [LEVEL_W-1:0] l);
    flow_item_t it;
    int         gap;
    it.cmd   = c;
    it.seek  = s;
    it.err   = e;
    it.level = l;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= it.cmd;
    item_ch.seek_time   <= it.seek;
    item_ch.error_code  <= it.err;
    item_ch.queue_count <= it.level;
    do @(posedge clk); while (!item_ch.ready);
    predict_actions(it);
    sent_items++;
  endtask

  // wait for every expected result, then for anything still in flight without one
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(cfg_reg_t idx, logic [LEVEL_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_UNDERFLOW) underflow_thr = value;
    else overflow_thr = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // levels clustered around the current thresholds, plus some drawn at random
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 6))
      0: return (underflow_thr == '0) ? '0 : underflow_thr - 1'b1;
      1: return underflow_thr;
      2: return overflow_thr;
      3: return (overflow_thr == '1) ? '1 : overflow_thr + 1'b1;
      4: return LEVEL_W'($urandom_range(0, underflow_thr));
      5: return LEVEL_W'($urandom_range(overflow_thr, 65535));
      default: return rand_level();
    endcase
  endfunction

  // result side: random stall after each transfer while idle_on is set, checked against the oldest expectation
  always @(posedge clk) begin : result_check
    action_record_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_actions.size() == 0) begin
          $error("unexpected result: action %0d time %0h error %0h last %0b",
                 result_ch.action, result_ch.command_time, result_ch.reported_error,
                 result_ch.last);
          fail_count++;
        end else begin
          want = expected_actions.pop_front();
          if (result_ch.action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, result_ch.action);
            fail_count++;
          end
          if (result_ch.command_time !== want.cmd_time) begin
            $error("command_time: expected %0h, got %0h", want.cmd_time,
                   result_ch.command_time);
            fail_count++;
          end
          if (result_ch.reported_error !== want.err) begin
            $error("reported_error: expected %0h, got %0h", want.err,
                   result_ch.reported_error);
            fail_count++;
          end
          if (result_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result_ch.last);
            fail_count++;
          end
        end
        sink_hold = idle_on ? $urandom_range(0, 10) : 0;
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      result_ch.ready <= (sink_hold == 0);
    end
  end

  // one pass through the stream with the reset thresholds, edges of every compare
  task automatic test_stream_bringup();
    send_item(CMD_LEVEL,    rand_time(), $urandom(), 16'd100);
    send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
    send_item(CMD_START,    '1, $urandom(), rand_level());
    send_item(CMD_START,    '0, '0, '0);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), '1);
    send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
    send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
    send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
    send_item(CMD_LEVEL,    rand_time(), $urandom(), OVERFLOW_RESET);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), UNDERFLOW_RESET);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), '0);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), OVERFLOW_RESET + 1'b1);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), '0);
    send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
    send_item(CMD_LEVEL,    rand_time(), $urandom(), '1);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), UNDERFLOW_RESET);
    send_item(CMD_LEVEL,    rand_time(), $urandom(), UNDERFLOW_RESET - 1'b1);
    send_item(CMD_COMPLETE, '1, '0, '1);
    settle();
  endtask

  // long stretch of the pause and resume loop under changing thresholds;
  // cancels and error completions are kept out since they end the stream for good
  task automatic test_random_flow();
    int                 phase_no;
    int                 span;
    int                 r;
    int                 base;
    cmd_t               c;
    logic [ERR_W-1:0]   e;
    logic [LEVEL_W-1:0] l;
    logic [LEVEL_W-1:0] lo;
    phase_no = 0;
    base     = sent_items;
    while (sent_items - base < 1500 && phase_no < 200) begin
      if (phase_no > 0) begin
        settle();
        case (phase_no % 5)
          0: begin
            write_threshold(REG_UNDERFLOW, UNDERFLOW_RESET);
            write_threshold(REG_OVERFLOW, OVERFLOW_RESET);
          end
          1: begin
            write_threshold(REG_UNDERFLOW, '0);
            write_threshold(REG_OVERFLOW, '1);
          end
          2: begin
            write_threshold(REG_UNDERFLOW, '1);
            write_threshold(REG_OVERFLOW, '0);
          end
          3: begin
            lo = LEVEL_W'($urandom_range(0, 100));
            write_threshold(REG_OVERFLOW, LEVEL_W'(lo + $urandom_range(0, 100)));
            write_threshold(REG_UNDERFLOW, lo);
          end
          default: begin
            write_threshold(REG_UNDERFLOW, rand_level());
            write_threshold(REG_OVERFLOW, rand_level());
          end
        endcase
      end
      // level items with these thresholds can never pause or resume the stream, so keep that phase short
      span    = (phase_no % 5 == 1) ? 25 : $urandom_range(40, 120);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        r = $urandom_range(0, 9);
        if (stream_busy()) c = (r < 7) ? CMD_COMPLETE : (r < 9) ? CMD_LEVEL : CMD_START;
        else c = (r < 8) ? CMD_LEVEL : (r == 8) ? CMD_COMPLETE : CMD_START;
        e = (c == CMD_COMPLETE) ? '0 : $urandom();
        l = (c == CMD_LEVEL) ? pick_level() : rand_level();
        send_item(c, rand_time(), e, l);
      end
      phase_no++;
    end
    settle();
    idle_on = 1'b1;
  endtask

  // inputs that the shutdown modes must drop
  task automatic send_shutdown_noise();
    send_item(CMD_START,  rand_time(), $urandom(), rand_level());
    send_item(CMD_LEVEL,  rand_time(), $urandom(), '1);
    send_item(CMD_LEVEL,  rand_time(), $urandom(), '0);
    send_item(CMD_CANCEL, rand_time(), $urandom(), rand_level());
  endtask

  // only one way into shutdown per run; the seed picks which
  task automatic test_shutdown();
    shutdown_path_t path;
    write_threshold(REG_UNDERFLOW, UNDERFLOW_RESET);
    write_threshold(REG_OVERFLOW, OVERFLOW_RESET);
    path = shutdown_path_t'($urandom_range(0, 2));
    case (path)
      END_CANCEL_BUSY: begin
        if (stream_phase == PH_PLAYING)
          send_item(CMD_LEVEL, rand_time(), $urandom(), OVERFLOW_RESET + 1'b1);
        else if (stream_phase == PH_PAUSED)
          send_item(CMD_LEVEL, rand_time(), $urandom(), '0);
        // cancel with a command outstanding holds teardown back for its completion
        send_item(CMD_CANCEL, rand_time(), $urandom(), rand_level());
        send_shutdown_noise();
        send_item(CMD_COMPLETE, rand_time(), $urandom() | 32'h1, rand_level());
      end
      END_CANCEL_IDLE: begin
        while (stream_busy()) send_item(CMD_COMPLETE, rand_time(), '0, rand_level());
        send_item(CMD_CANCEL, rand_time(), $urandom(), rand_level());
      end
      default: begin
        send_item(CMD_COMPLETE, rand_time(), '1, rand_level());
      end
    endcase
    send_shutdown_noise();
    send_item(CMD_COMPLETE, rand_time(), $urandom() | 32'h1, rand_level());
    settle();
  endtask

  task automatic test_terminated_inputs();
    send_item(CMD_COMPLETE, '1, '1, '1);
    send_item(CMD_START, '1, '0, '0);
    repeat (40)
      send_item(cmd_t'(CMD_W'($urandom_range(0, 3))), rand_time(), $urandom(),
                rand_level());
    settle();
  endtask

  initial begin
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = CMD_START;
    item_ch.seek_time   = '0;
    item_ch.error_code  = '0;
    item_ch.queue_count = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_UNDERFLOW;
    cfg_ch.data         = '0;
    result_ch.ready     = 1'b0;
    stream_phase        = PH_IDLE;
    shutdown_mode       = MD_NORMAL;
    underflow_thr       = UNDERFLOW_RESET;
    overflow_thr        = OVERFLOW_RESET;
    fail_count          = 0;
    sent_items          = 0;
    idle_on             = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_stream_bringup();
    test_random_flow();
    test_shutdown();
    test_terminated_inputs();

    if (fail_count == 0 && expected_actions.size() == 0) begin
      $display("playback_flow_sequencer verification clean");
    end else begin
      $display("playback_flow_sequencer verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pfs_pkg.sv
rtl/pfs_ifs.sv
rtl/pfs_front.sv
rtl/pfs_queue.sv
rtl/pfs_back.sv
rtl/playback_flow_sequencer.sv
tb/playback_flow_sequencer_tb.sv
